@@ design/psd_pkg.sv @@
package psd_pkg;

	// default configuration
	localparam int COORD_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF   = 8;

	// which part of the segment the answer refers to
	typedef enum logic [1:0] {
		REG_INTERIOR = 2'd0,
		REG_START    = 2'd1,
		REG_END      = 2'd2,
		REG_ZERO     = 2'd3
	} region_t;

	// control that travels alongside the data of one item
	typedef struct packed {
		logic    valid;
		region_t region;
	} tag_t;

endpackage

@@ design/psd_div.sv @@
module psd_div import psd_pkg::*; #(
	parameter int LW  = 34,
	parameter int NW  = 68,
	parameter int QW  = 50,
	parameter int NPW = 84
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  tag_t          tag_in,
	input  logic [NW-1:0] num,
	input  logic [LW-1:0] den,
	output tag_t          tag_out,
	output logic [QW-1:0] quot
);

	// scaled dividend; the bits above the quotient are already below den
	logic [NPW-1:0] dvd;
	assign dvd = NPW'(num) << (NPW - NW);

	logic [LW-1:0] rem_s [QW+1];
	logic [QW-1:0] x_s   [QW+1];
	logic [LW-1:0] den_s [QW+1];
	logic          vld_s [QW+1];
	region_t       reg_s [QW+1];

	assign rem_s[0] = dvd[NPW-1:QW];
	assign x_s[0]   = dvd[QW-1:0];
	assign den_s[0] = den;
	assign vld_s[0] = tag_in.valid;
	assign reg_s[0] = tag_in.region;

	// one quotient bit per stage, restoring
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [LW:0] trial;
		logic        ge;
		assign trial = {rem_s[k], x_s[k][QW-1]};
		assign ge    = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				reg_s[k+1]  <= reg_s[k];
				rem_s[k+1]  <= ge ? LW'(trial - {1'b0, den_s[k]}) : LW'(trial);
				x_s[k+1]    <= {x_s[k][QW-2:0], ge};
				den_s[k+1]  <= den_s[k];
			end
		end
	end

	assign tag_out = '{valid: vld_s[QW], region: reg_s[QW]};
	assign quot    = x_s[QW];

endmodule

@@ design/psd_sqrt.sv @@
module psd_sqrt import psd_pkg::*; #(
	parameter int DW = 25
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  tag_t            tag_in,
	input  logic [2*DW-1:0] radicand,
	output tag_t            tag_out,
	output logic [DW-1:0]   root
);

	localparam int QW = 2 * DW;

	logic [DW:0]   rem_s  [DW+1];
	logic [DW-1:0] root_s [DW+1];
	logic [QW-1:0] x_s    [DW+1];
	logic          vld_s  [DW+1];
	region_t       reg_s  [DW+1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign x_s[0]    = radicand;
	assign vld_s[0]  = tag_in.valid;
	assign reg_s[0]  = tag_in.region;

	// one root bit per stage, two radicand bits brought down each time
	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [DW+2:0] trial;
		logic [DW+2:0] test;
		logic          ge;
		assign trial = {rem_s[k], x_s[k][QW-1:QW-2]};
		assign test  = {1'b0, root_s[k], 2'b01};
		assign ge    = trial >= test;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				reg_s[k+1]  <= reg_s[k];
				rem_s[k+1]  <= ge ? (DW+1)'(trial - test) : (DW+1)'(trial);
				root_s[k+1] <= {root_s[k][DW-2:0], ge};
				x_s[k+1]    <= {x_s[k][QW-3:0], 2'b00};
			end
		end
	end

	assign tag_out = '{valid: vld_s[DW], region: reg_s[DW]};
	assign root    = root_s[DW];

endmodule

@@ design/point_segment_distance_3d.sv @@
// channel  signals                                        direction
// in       in_valid, in_ready, point_*, start_*, end_*    into the block
// out      out_valid, out_ready, seg_distance, region     out of the block
//
// one item per cycle while no result waits unread; the divider has one
// quotient bit per stage and the square root one root bit per stage,
// DW = COORD_WIDTH + 1 + FRAC_BITS
// reset clears the valid bits only; no clearing pass
// the whole pipeline moves together; it holds while a result waits unread
module point_segment_distance_3d import psd_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int DW         = COORD_WIDTH + 1 + FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic signed [COORD_WIDTH-1:0] start_x,
	input  logic signed [COORD_WIDTH-1:0] start_y,
	input  logic signed [COORD_WIDTH-1:0] start_z,
	input  logic signed [COORD_WIDTH-1:0] end_x,
	input  logic signed [COORD_WIDTH-1:0] end_y,
	input  logic signed [COORD_WIDTH-1:0] end_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [DW-1:0]                 seg_distance,
	output logic [1:0]                    region
);

	localparam int DFW = COORD_WIDTH + 1;
	localparam int LW  = 2 * DFW;
	localparam int DTW = 2 * DFW + 1;
	localparam int NW  = 4 * DFW;
	localparam int QW  = 2 * DW;
	localparam int NPW = NW + 2 * FRAC_BITS;

	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// stage valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: difference vectors
	logic signed [DFW-1:0] a_s1 [3];
	logic signed [DFW-1:0] b_s1 [3];
	logic signed [DFW-1:0] e_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1[0] <= DFW'(end_x) - DFW'(start_x);
			a_s1[1] <= DFW'(end_y) - DFW'(start_y);
			a_s1[2] <= DFW'(end_z) - DFW'(start_z);
			b_s1[0] <= DFW'(point_x) - DFW'(start_x);
			b_s1[1] <= DFW'(point_y) - DFW'(start_y);
			b_s1[2] <= DFW'(point_z) - DFW'(start_z);
			e_s1[0] <= DFW'(point_x) - DFW'(end_x);
			e_s1[1] <= DFW'(point_y) - DFW'(end_y);
			e_s1[2] <= DFW'(point_z) - DFW'(end_z);
		end
	end

	// stage 2: products
	logic signed [LW-1:0] aa_s2 [3];
	logic signed [LW-1:0] ab_s2 [3];
	logic signed [LW-1:0] bb_s2 [3];
	logic signed [LW-1:0] ee_s2 [3];
	logic signed [LW-1:0] cp_s2 [6];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				aa_s2[i] <= LW'(a_s1[i]) * LW'(a_s1[i]);
				ab_s2[i] <= LW'(a_s1[i]) * LW'(b_s1[i]);
				bb_s2[i] <= LW'(b_s1[i]) * LW'(b_s1[i]);
				ee_s2[i] <= LW'(e_s1[i]) * LW'(e_s1[i]);
			end
			cp_s2[0] <= LW'(a_s1[1]) * LW'(b_s1[2]);
			cp_s2[1] <= LW'(a_s1[2]) * LW'(b_s1[1]);
			cp_s2[2] <= LW'(a_s1[2]) * LW'(b_s1[0]);
			cp_s2[3] <= LW'(a_s1[0]) * LW'(b_s1[2]);
			cp_s2[4] <= LW'(a_s1[0]) * LW'(b_s1[1]);
			cp_s2[5] <= LW'(a_s1[1]) * LW'(b_s1[0]);
		end
	end

	// stage 3: sums and cross product
	logic [LW-1:0]         len2_s3, sb_s3, se_s3;
	logic signed [DTW-1:0] dot_s3;
	logic signed [LW-1:0]  c_s3 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			len2_s3 <= LW'(aa_s2[0]) + LW'(aa_s2[1]) + LW'(aa_s2[2]);
			sb_s3   <= LW'(bb_s2[0]) + LW'(bb_s2[1]) + LW'(bb_s2[2]);
			se_s3   <= LW'(ee_s2[0]) + LW'(ee_s2[1]) + LW'(ee_s2[2]);
			dot_s3  <= DTW'(ab_s2[0]) + DTW'(ab_s2[1]) + DTW'(ab_s2[2]);
			c_s3[0] <= cp_s2[0] - cp_s2[1];
			c_s3[1] <= cp_s2[2] - cp_s2[3];
			c_s3[2] <= cp_s2[4] - cp_s2[5];
		end
	end

	// stage 4: cross squares and region decision
	region_t       region_s4;
	logic [NW-1:0] c2_s4 [3];
	logic [LW-1:0] len2_s4, sb_s4, se_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c2_s4[i] <= NW'(c_s3[i]) * NW'(c_s3[i]);
			end
			len2_s4 <= len2_s3;
			sb_s4   <= sb_s3;
			se_s4   <= se_s3;
			if (len2_s3 == '0) begin
				region_s4 <= REG_ZERO;
			end else if (dot_s3 < 0) begin
				region_s4 <= REG_START;
			end else if (dot_s3 > $signed({1'b0, len2_s3})) begin
				region_s4 <= REG_END;
			end else begin
				region_s4 <= REG_INTERIOR;
			end
		end
	end

	// stage 5: pick numerator and denominator
	region_t       region_s5;
	logic [NW-1:0] num_s5;
	logic [LW-1:0] den_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			region_s5 <= region_s4;
			case (region_s4)
				REG_INTERIOR: begin
					num_s5 <= c2_s4[0] + c2_s4[1] + c2_s4[2];
					den_s5 <= len2_s4;
				end
				REG_END: begin
					num_s5 <= NW'(se_s4);
					den_s5 <= LW'(1);
				end
				default: begin
					num_s5 <= NW'(sb_s4);
					den_s5 <= LW'(1);
				end
			endcase
		end
	end

	tag_t          tag_s5, tag_dq, tag_rt;
	logic [QW-1:0] quot;
	assign tag_s5 = '{valid: v_s5, region: region_s5};

	// squared distance, scaled, as an integer quotient
	psd_div #(
		.LW  (LW),
		.NW  (NW),
		.QW  (QW),
		.NPW (NPW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_s5),
		.num     (num_s5),
		.den     (den_s5),
		.tag_out (tag_dq),
		.quot    (quot)
	);

	// floor square root of the quotient
	psd_sqrt #(
		.DW (DW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.tag_in   (tag_dq),
		.radicand (quot),
		.tag_out  (tag_rt),
		.root     (seg_distance)
	);

	assign out_valid = tag_rt.valid;
	assign region    = tag_rt.region;

`ifndef NO_ASSERTIONS
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1)
		else $error("accepted item not in stage 1");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s3 && len2_s3 == '0 |=> region_s4 == REG_ZERO)
		else $error("zero-length segment not flagged");
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s4 && region_s4 != REG_INTERIOR |=> den_s5 == LW'(1))
		else $error("end point distance with non-unit divisor");
`endif

endmodule
